// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; cons may begin with its own delay operator.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lruc_pkg.sv -----
// Package for the LRU key-value cache: sizes, opcodes and cell control.
package lruc_pkg;

	localparam int ENTRIES = 16;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		logic take_prev;
		logic take_front;
		logic valid_we;
		logic valid_d;
	} cell_ctrl_t;

	// Bits strictly below position pos set.
	function automatic logic [ENTRIES-1:0] low_mask(input int pos);
		logic [ENTRIES-1:0] m;
		for (int j = 0; j < ENTRIES; j++) begin
			m[j] = (j < pos);
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/lruc_cell.sv -----
// One slot of the recency stack: key, value, valid mark and key compare.
module lruc_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lruc_pkg::cell_ctrl_t              ctrl,
	input  logic signed [lruc_pkg::DATA_W-1:0] cmp_key,
	input  logic signed [lruc_pkg::DATA_W-1:0] prev_key,
	input  logic signed [lruc_pkg::DATA_W-1:0] prev_value,
	input  logic signed [lruc_pkg::DATA_W-1:0] front_key,
	input  logic signed [lruc_pkg::DATA_W-1:0] front_value,
	output logic signed [lruc_pkg::DATA_W-1:0] key,
	output logic signed [lruc_pkg::DATA_W-1:0] value,
	output logic                              match
);

	logic signed [lruc_pkg::DATA_W-1:0] key_q;
	logic signed [lruc_pkg::DATA_W-1:0] value_q;
	logic                              valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.take_front) begin
			key_q   <= front_key;
			value_q <= front_value;
		end else if (ctrl.take_prev) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.valid_we) begin
			valid_q <= ctrl.valid_d;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = valid_q && (key_q == cmp_key);

endmodule

// ----- hw/rtl/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: input stage, cell row control, result register.
// Flow: an item waits in the input stage until the result register is free; then its
// result is registered and out_valid rises. The input stage holds one item and takes
// no other while full; the cell row compares all keys and shifts the recency stack.
// Reset: valid marks and occupancy clear, capacity returns to 16; no clearing pass.
module lru_key_value_cache_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [lruc_pkg::CAP_W-1:0]        cfg_write_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic signed [lruc_pkg::DATA_W-1:0] lookup_key,
	input  logic signed [lruc_pkg::DATA_W-1:0] write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [lruc_pkg::DATA_W-1:0] read_value
);

	localparam int N = lruc_pkg::ENTRIES;

	logic [lruc_pkg::CAP_W-1:0]         cap_q;
	logic [lruc_pkg::OCC_W-1:0]         occ_q;
	logic                               valid_s1;
	lruc_pkg::op_t                      op_s1;
	logic signed [lruc_pkg::DATA_W-1:0] key_s1;
	logic signed [lruc_pkg::DATA_W-1:0] value_s1;
	logic                               out_valid_q;
	logic                               hit_q;
	logic signed [lruc_pkg::DATA_W-1:0] read_value_q;

	logic signed [lruc_pkg::DATA_W-1:0] cell_key   [N];
	logic signed [lruc_pkg::DATA_W-1:0] cell_value [N];
	logic [N-1:0]                       match;
	logic [N-1:0]                       first;
	logic [N-1:0]                       upto;
	lruc_pkg::cell_ctrl_t               ctrl [N];

	logic                               fire;
	logic                               found;
	logic signed [lruc_pkg::DATA_W-1:0] sel_value;
	logic signed [lruc_pkg::DATA_W-1:0] front_value;
	logic [lruc_pkg::OCC_W-1:0]         cap_eff;
	logic [lruc_pkg::OCC_W-1:0]         occ_keep;
	logic [lruc_pkg::OCC_W-1:0]         new_occ;
	logic                               ins;

	assign in_ready = !valid_s1;
	assign fire     = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lruc_pkg::CAP_RESET;
		end else if (cfg_write_en) begin
			cap_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= lruc_pkg::op_t'(opcode);
			key_s1   <= lookup_key;
			value_s1 <= write_value;
		end
	end

	generate
		for (genvar i = 0; i < N; i++) begin : g_cell
			if (i == 0) begin : g_head
				lruc_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl[i]),
					.cmp_key    (key_s1),
					.prev_key   (key_s1),
					.prev_value (front_value),
					.front_key  (key_s1),
					.front_value(front_value),
					.key        (cell_key[i]),
					.value      (cell_value[i]),
					.match      (match[i])
				);
			end else begin : g_body
				lruc_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl[i]),
					.cmp_key    (key_s1),
					.prev_key   (cell_key[i-1]),
					.prev_value (cell_value[i-1]),
					.front_key  (key_s1),
					.front_value(front_value),
					.key        (cell_key[i]),
					.value      (cell_value[i]),
					.match      (match[i])
				);
			end
		end
	endgenerate

	// first match, slots at or before it, and its value
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < N; i++) begin
			first[i] = match[i] && !(|(match & lruc_pkg::low_mask(i)));
		end
		for (int i = 0; i < N; i++) begin
			upto[i] = |(first & ~lruc_pkg::low_mask(i));
			if (first[i]) begin
				sel_value = sel_value | cell_value[i];
			end
		end
		found = |match;
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lruc_pkg::OCC_W'(1);
		end else if (int'(cap_q) > N) begin
			cap_eff = lruc_pkg::OCC_W'(N);
		end else begin
			cap_eff = lruc_pkg::OCC_W'(cap_q);
		end
		occ_keep    = (occ_q >= cap_eff) ? (cap_eff - 1'b1) : occ_q;
		new_occ     = occ_keep + 1'b1;
		ins         = fire && !found && (op_s1 == lruc_pkg::OP_PUT);
		front_value = (op_s1 == lruc_pkg::OP_PUT) ? value_s1 : sel_value;
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctrl[i] = '0;
			if (fire && found) begin
				ctrl[i].take_front = (i == 0);
				ctrl[i].take_prev  = (i != 0) && upto[i];
			end else if (ins) begin
				ctrl[i].take_front = (i == 0);
				ctrl[i].take_prev  = (i != 0) && (lruc_pkg::OCC_W'(i) < new_occ);
				ctrl[i].valid_we   = 1'b1;
				ctrl[i].valid_d    = (lruc_pkg::OCC_W'(i) < new_occ);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ins) begin
			occ_q <= new_occ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q <= found;
			if (op_s1 == lruc_pkg::OP_PUT) begin
				read_value_q <= '0;
			end else if (found) begin
				read_value_q <= sel_value;
			end else begin
				read_value_q <= lruc_pkg::MISS_VALUE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

// ----- hw/rtl/lruc_checker.sv -----
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "assert_macros.svh"

module lruc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic signed [lruc_pkg::DATA_W-1:0] read_value
);

	`CHK_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer accepted while busy")
	`CHK_SAME(a_latency, clk, arst_n, in_valid && in_ready && !out_valid, ##2 out_valid, "result late")
	`CHK_SAME(a_miss_value, clk, arst_n, out_valid && !hit, read_value == lruc_pkg::MISS_VALUE || read_value == '0, "bad miss value")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(read_value), "stalled result changed")

endmodule

bind lru_key_value_cache_unit lruc_checker u_lruc_checker (.*);

// ----- tb/lru_key_value_cache_unit_tb.sv -----
// Self-checking LRU key-value cache bench: directed and random traffic, model scoreboard.
module lru_key_value_cache_unit_tb;
	import lruc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		op_t                      op;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} access_t;

	typedef struct {
		logic                     hit;
		logic signed [DATA_W-1:0] value;
	} lookup_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write_en = 1'b0;
	logic [CAP_W-1:0]          cfg_write_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      opcode = 1'b0;
	logic signed [DATA_W-1:0]  lookup_key = '0;
	logic signed [DATA_W-1:0]  write_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      hit;
	logic signed [DATA_W-1:0]  read_value;

	access_t pending_accesses[$];
	lookup_t lookups_due[$];
	logic    in_took = 1'b0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	bit      hold_trigger = 1'b0;
	int      hold_left = 0;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	logic signed [DATA_W-1:0] key_pool[24];

	// cache model: slot 0 is most recently used
	logic [DATA_W-1:0] lru_keys[ENTRIES];
	logic [DATA_W-1:0] lru_values[ENTRIES];
	int                lru_fill = 0;
	logic [CAP_W-1:0]  lru_capacity = CAP_RESET;

	lru_key_value_cache_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.lookup_key     (lookup_key),
		.write_value    (write_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.read_value     (read_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void move_to_front(int pos);
		logic [DATA_W-1:0] k;
		logic [DATA_W-1:0] v;
		k = lru_keys[pos];
		v = lru_values[pos];
		for (int i = pos; i > 0; i--) begin
			lru_keys[i] = lru_keys[i-1];
			lru_values[i] = lru_values[i-1];
		end
		lru_keys[0] = k;
		lru_values[0] = v;
	endfunction

	function automatic lookup_t cache_access(access_t a);
		lookup_t r;
		int slot;
		int cap;
		slot = -1;
		for (int i = 0; i < lru_fill; i++) begin
			if (slot < 0 && lru_keys[i] == a.key) begin
				slot = i;
			end
		end
		r.hit = (slot >= 0);
		cap = (lru_capacity == 0) ? 1 : (lru_capacity > ENTRIES) ? ENTRIES : lru_capacity;
		if (a.op == OP_GET) begin
			if (r.hit) begin
				move_to_front(slot);
				r.value = lru_values[0];
			end else begin
				r.value = MISS_VALUE;
			end
		end else begin
			if (r.hit) begin
				lru_values[slot] = a.value;
				move_to_front(slot);
			end else begin
				while (lru_fill >= cap) begin
					lru_fill--;
				end
				for (int i = lru_fill; i > 0; i--) begin
					lru_keys[i] = lru_keys[i-1];
					lru_values[i] = lru_values[i-1];
				end
				lru_keys[0] = a.key;
				lru_values[0] = a.value;
				lru_fill++;
			end
			r.value = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (mismatch_count < 50) begin
			$display("mismatch %s: expected %h, got %h at cycle %0d", what, want, got, cycle_count);
		end
		mismatch_count++;
	endtask

	// driver
	always @(negedge clk) begin
		access_t nxt;
		if (arst_n && !(in_valid && !in_took)) begin
			if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_accesses.pop_front();
				opcode <= nxt.op;
				lookup_key <= nxt.key;
				write_value <= nxt.value;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_trigger) begin
			hold_left = HOLD_CYCLES;
			hold_trigger = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		access_t a;
		lookup_t want;
		if (arst_n) begin
			if (cfg_write_en) begin
				lru_capacity = cfg_write_data;
			end
			if (in_valid && in_ready) begin
				a.op = op_t'(opcode);
				a.key = lookup_key;
				a.value = write_value;
				lookups_due.push_back(cache_access(a));
			end
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					report_mismatch("unexpected transfer", '0, read_value);
				end else begin
					want = lookups_due.pop_front();
					if (hit !== want.hit) begin
						report_mismatch("hit", DATA_W'(want.hit), DATA_W'(hit));
					end
					if (read_value !== want.value) begin
						report_mismatch("read_value", want.value, read_value);
					end
				end
			end
		end
		in_took <= arst_n && in_valid && in_ready;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", lookups_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_access(op_t op, logic signed [DATA_W-1:0] key, logic signed [DATA_W-1:0] value);
		access_t a;
		a.op = op;
		a.key = key;
		a.value = value;
		pending_accesses.push_back(a);
	endtask

	task automatic wait_drain();
		do begin
			@(posedge clk);
		end while (pending_accesses.size() != 0 || in_valid || lookups_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= cap;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic add_random(int n, int pool_n);
		logic signed [DATA_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
			add_access($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom);
		end
	endtask

	task automatic run_phase(logic [CAP_W-1:0] cap, int send_pct, int recv_pct, int n, int pool_n);
		write_capacity(cap);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		add_random(n, pool_n);
		wait_drain();
	endtask

	initial begin
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = -32'sd1;
		key_pool[3] = 32'sd0;
		for (int i = 4; i < 24; i++) begin
			key_pool[i] = $urandom;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// capacity at reset value
		add_access(OP_GET, 32'sd0, 32'sd7);
		add_access(OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
		add_access(OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
		add_access(OP_PUT, -32'sd1, -32'sd1);
		add_access(OP_PUT, 32'sd0, 32'sd0);
		add_access(OP_GET, 32'sh8000_0000, 32'sd0);
		add_access(OP_GET, -32'sd1, 32'sd0);
		add_access(OP_GET, 32'sd12345, 32'sd0);
		add_access(OP_PUT, 32'sh7fff_ffff, 32'sd5);
		add_access(OP_GET, 32'sh7fff_ffff, 32'sd0);
		for (int i = 1; i <= 4; i++) begin
			add_access(OP_PUT, i, $urandom);
		end
		wait_drain();

		// shrink below occupancy: present keys still hit, next insert trims
		write_capacity(CAP_W'(2));
		add_access(OP_GET, 32'sh8000_0000, 32'sd0);
		add_access(OP_PUT, 32'sd99, 32'sd1234);
		add_access(OP_GET, 32'sd0, 32'sd0);
		add_access(OP_GET, 32'sd99, 32'sd0);
		wait_drain();

		// zero capacity behaves as one
		write_capacity(CAP_W'(0));
		add_access(OP_PUT, 32'sd5, 32'sd55);
		add_access(OP_PUT, 32'sd6, 32'sd66);
		add_access(OP_GET, 32'sd5, 32'sd0);
		add_access(OP_GET, 32'sd6, 32'sd0);
		wait_drain();

		run_phase(CAP_W'(31), 0, 0, 300, 20);
		run_phase(CAP_W'(1), 60, 0, 250, 3);
		run_phase(CAP_W'(4), 0, 60, 250, 6);
		run_phase(CAP_W'(16), 28, 28, 350, 20);

		// long receiver hold-off while the sender keeps offering
		write_capacity(CAP_W'(17));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_trigger = 1'b1;
		add_random(150, 22);
		wait_drain();

		run_phase(CAP_W'($urandom_range(0, 31)), 28, 28, 300, 14);
		run_phase(CAP_W'($urandom_range(1, 16)), 60, 60, 200, 12);
		run_phase(CAP_W'(8), 0, 0, 200, 10);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- lru_key_value_cache_unit.f -----
+incdir+hw/rtl
hw/rtl/lruc_pkg.sv
hw/rtl/lruc_cell.sv
hw/rtl/lru_key_value_cache_unit.sv
hw/rtl/lruc_checker.sv
tb/lru_key_value_cache_unit_tb.sv
